// ----- rtl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is held
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// same, with no reset qualifier
`define CHK_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/ghf_pkg.sv -----
package ghf_pkg;

    // default geometry of the histogram store
    localparam int SPECTRA_DEF  = 4;
    localparam int CHANNELS_DEF = 32768;

    // field and bus widths
    localparam int REG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int VAL_W       = 32;
    localparam int PROD_W      = 64;
    localparam int FRAC_W      = 16;
    localparam int INT_W       = PROD_W - FRAC_W;
    localparam int OP_W        = 2;
    localparam int BSP_W       = 2;
    localparam int BCH_W       = 15;
    localparam int CNT_W       = 32;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 56;

    // operation codes
    localparam logic [OP_W-1:0] OP_FILL     = 2'd0;
    localparam logic [OP_W-1:0] OP_READ     = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_CLR = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SORT_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SORT_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_GAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_OFFSET = 2'd3;

    // register reset values
    localparam logic [REG_W-1:0] GAIN_ONE = 32'h0001_0000;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_GMUL,
        S_GADD,
        S_GCHK,
        S_SMUL,
        S_SADD,
        S_SCHK,
        S_RD,
        S_UPD,
        S_DROP
    } t_state;

    // controls for the shared multiply-add unit
    typedef struct packed {
        logic mul_en;
        logic add_en;
    } t_mac_ctrl;

endpackage

// ----- rtl/ghf_mac.sv -----
module ghf_mac
    import ghf_pkg::*;
(
    input  logic                     i_clk,
    input  t_mac_ctrl                i_ctrl,
    input  logic signed [VAL_W-1:0]  i_a,
    input  logic signed [REG_W-1:0]  i_gain,
    input  logic signed [REG_W-1:0]  i_offset,
    output logic signed [PROD_W-1:0] o_sum
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_sum;

    // exact signed product, registered
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= PROD_W'(i_a * i_gain);
        end
    end

    // add the sign-extended q16.16 offset
    always_ff @(posedge i_clk) begin
        if (i_ctrl.add_en) begin
            r_sum <= r_prod + PROD_W'(i_offset);
        end
    end

    assign o_sum = r_sum;

endmodule

// ----- rtl/ghf_store.sv -----
module ghf_store
    import ghf_pkg::*;
#(
    parameter int DEPTH  = SPECTRA_DEF * CHANNELS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [CNT_W-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [CNT_W-1:0]  o_rdata
);

    logic [CNT_W-1:0] r_mem [DEPTH];
    logic [CNT_W-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/gated_histogram_filler.sv -----
// channel   dir   beat fields (low bit first)
// s_axis    in    tuser: op | tdata: sort_raw, gate_raw, read_spectrum, read_channel
// m_axis    out   tuser: accepted | tdata: bin_spectrum, bin_channel, bin_count
// i_cfg     in    index 0 sort_gain, 1 sort_offset, 2 gate_gain, 3 gate_offset
//
// a fill passes gate and sort each through the shared multiply-add unit (multiply,
// add, range check), then makes one read and one write of the bin store, which
// has one write port and one registered read port. a read or read-and-clear makes
// one read and, for read-and-clear, one write; items dropped at decode or by a
// range check go to the drop state. after reset a clearing pass writes zero to all
// SPECTRA*CHANNELS bins (131072 by default) with s_axis_tready low.
// a finished result sits in the output register while the next beat is taken;
// a result that cannot be stored yet holds the sequencer in its last state.
module gated_histogram_filler
    import ghf_pkg::*;
#(
    parameter int SPECTRA  = SPECTRA_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sort_raw, gate_raw, read_spectrum, read_channel
    input  logic [OP_W-1:0]        s_axis_tuser,  // op
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // bin_spectrum, bin_channel, bin_count
    output logic [0:0]             m_axis_tuser,  // accepted
    // register writes
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [REG_W-1:0]       i_cfg_wdata
);

    localparam int NBINS  = SPECTRA * CHANNELS;
    localparam int ADDR_W = $clog2(NBINS);
    localparam int SP_W   = (SPECTRA > 1) ? $clog2(SPECTRA) : 1;
    localparam int CH_W   = $clog2(CHANNELS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NBINS - 1);
    localparam logic [ADDR_W-1:0] CH_MUL    = ADDR_W'(CHANNELS);
    localparam logic [INT_W-1:0]  SP_LIM    = INT_W'(SPECTRA);
    localparam logic [INT_W-1:0]  CH_LIM    = INT_W'(CHANNELS);
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

    // input beat fields
    logic [OP_W-1:0]         in_op;
    logic signed [VAL_W-1:0] in_sort;
    logic signed [VAL_W-1:0] in_gate;
    logic [BSP_W-1:0]        in_rsp;
    logic [BCH_W-1:0]        in_rch;

    assign in_op   = s_axis_tuser;
    assign in_sort = s_axis_tdata[31:0];
    assign in_gate = s_axis_tdata[63:32];
    assign in_rsp  = s_axis_tdata[65:64];
    assign in_rch  = s_axis_tdata[80:66];

    t_state r_state, n_state;

    // configuration
    logic [REG_W-1:0] r_sort_gain, r_sort_offset, r_gate_gain, r_gate_offset;

    // item registers
    logic [OP_W-1:0]         r_op;
    logic signed [VAL_W-1:0] r_sort;
    logic signed [VAL_W-1:0] r_gate;
    logic [SP_W-1:0]         r_sp_idx;
    logic [BSP_W-1:0]        r_bsp;
    logic [BCH_W-1:0]        r_bch;
    logic [ADDR_W-1:0]       r_addr;
    logic [ADDR_W-1:0]       r_clr_addr;

    // output register
    logic                    r_ovalid;
    logic                    r_oacc;
    logic [BSP_W-1:0]        r_obsp;
    logic [BCH_W-1:0]        r_obch;
    logic [CNT_W-1:0]        r_ocnt;

    // control from the output decoder
    t_mac_ctrl               mac_ctrl;
    logic                    mac_sel_gate;
    logic                    mem_we;
    logic                    out_load;
    logic                    out_free;
    logic                    in_take;

    // shared unit and store signals
    logic signed [VAL_W-1:0]  mac_a;
    logic signed [REG_W-1:0]  mac_gain;
    logic signed [REG_W-1:0]  mac_offset;
    logic signed [PROD_W-1:0] mac_sum;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [CNT_W-1:0]         mem_wdata;
    logic [CNT_W-1:0]         mem_rdata;
    logic [CNT_W-1:0]         sat_cnt;

    // decode of the scaled value
    logic [INT_W-1:0]  sum_int;
    logic              gate_neg_small;
    logic              gate_ok;
    logic [INT_W-1:0]  gate_sp;
    logic              sort_ok;
    logic              rd_in_range;
    logic [SP_W-1:0]   addr_sp;
    logic [CH_W-1:0]   addr_ch;
    logic [ADDR_W-1:0] addr_calc;

    assign out_free = !r_ovalid || m_axis_tready;
    assign in_take  = s_axis_tvalid && s_axis_tready;

    // shared multiply-add unit, fed gate or sort operands
    assign mac_a      = mac_sel_gate ? r_gate : r_sort;
    assign mac_gain   = mac_sel_gate ? r_gate_gain : r_sort_gain;
    assign mac_offset = mac_sel_gate ? r_gate_offset : r_sort_offset;

    ghf_mac u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (mac_ctrl),
        .i_a      (mac_a),
        .i_gain   (mac_gain),
        .i_offset (mac_offset),
        .o_sum    (mac_sum)
    );

    // range checks on the q.16 result
    assign sum_int        = mac_sum[PROD_W-1:FRAC_W];
    assign gate_neg_small = mac_sum[PROD_W-1] && (&sum_int) && (|mac_sum[FRAC_W-1:0]);
    assign gate_sp        = gate_neg_small ? '0 : sum_int;
    assign gate_ok        = gate_neg_small || (!mac_sum[PROD_W-1] && (sum_int < SP_LIM));
    assign sort_ok        = !mac_sum[PROD_W-1] && (sum_int < CH_LIM);
    assign rd_in_range    = (VAL_W'(in_rsp) < VAL_W'(SPECTRA))
                         && (VAL_W'(in_rch) < VAL_W'(CHANNELS));

    // bin address: spectrum * CHANNELS + channel
    always_comb begin
        if (r_state == S_IDLE) begin
            addr_sp = SP_W'(in_rsp);
            addr_ch = CH_W'(in_rch);
        end else begin
            addr_sp = r_sp_idx;
            addr_ch = sum_int[CH_W-1:0];
        end
    end
    assign addr_calc = ADDR_W'(addr_sp) * CH_MUL + ADDR_W'(addr_ch);

    // saturating increment
    assign sat_cnt = (mem_rdata == CNT_MAX) ? mem_rdata : mem_rdata + 1'b1;

    // bin store
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign mem_wdata = (r_state != S_CLEAR && r_op == OP_FILL) ? sat_cnt : '0;

    ghf_store #(
        .DEPTH  (NBINS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_take) begin
                    if (in_op == OP_FILL) begin
                        n_state = S_GMUL;
                    end else if ((in_op == OP_READ || in_op == OP_READ_CLR) && rd_in_range) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_DROP;
                    end
                end
            end
            S_GMUL: n_state = S_GADD;
            S_GADD: n_state = S_GCHK;
            S_GCHK: n_state = gate_ok ? S_SMUL : S_DROP;
            S_SMUL: n_state = S_SADD;
            S_SADD: n_state = S_SCHK;
            S_SCHK: n_state = sort_ok ? S_RD : S_DROP;
            S_RD:   n_state = S_UPD;
            S_UPD: begin
                if (out_free) n_state = S_IDLE;
            end
            S_DROP: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready   = 1'b0;
        mac_ctrl        = '0;
        mac_sel_gate    = 1'b0;
        mem_we          = 1'b0;
        out_load        = 1'b0;
        case (r_state)
            S_CLEAR: mem_we = 1'b1;
            S_IDLE:  s_axis_tready = 1'b1;
            S_GMUL: begin
                mac_ctrl.mul_en = 1'b1;
                mac_sel_gate    = 1'b1;
            end
            S_GADD: begin
                mac_ctrl.add_en = 1'b1;
                mac_sel_gate    = 1'b1;
            end
            S_SMUL:  mac_ctrl.mul_en = 1'b1;
            S_SADD:  mac_ctrl.add_en = 1'b1;
            S_UPD: begin
                out_load = out_free;
                mem_we   = out_free && (r_op != OP_READ);
            end
            S_DROP:  out_load = out_free;
            default: ;
        endcase
    end

    // clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == S_CLEAR) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_gain   <= GAIN_ONE;
            r_sort_offset <= '0;
            r_gate_gain   <= GAIN_ONE;
            r_gate_offset <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SORT_GAIN:   r_sort_gain   <= i_cfg_wdata;
                REG_SORT_OFFSET: r_sort_offset <= i_cfg_wdata;
                REG_GATE_GAIN:   r_gate_gain   <= i_cfg_wdata;
                REG_GATE_OFFSET: r_gate_offset <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // item registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    r_op   <= in_op;
                    r_sort <= in_sort;
                    r_gate <= in_gate;
                    r_addr <= addr_calc;
                    if (in_op == OP_READ || in_op == OP_READ_CLR) begin
                        r_bsp <= in_rsp;
                        r_bch <= in_rch;
                    end else begin
                        r_bsp <= '0;
                        r_bch <= '0;
                    end
                end
            end
            S_GCHK: begin
                if (gate_ok) begin
                    r_sp_idx <= gate_sp[SP_W-1:0];
                    r_bsp    <= gate_sp[BSP_W-1:0];
                end
            end
            S_SCHK: begin
                if (sort_ok) begin
                    r_bch  <= sum_int[BCH_W-1:0];
                    r_addr <= addr_calc;
                end else begin
                    r_bsp  <= '0;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_obsp <= r_bsp;
            r_obch <= r_bch;
            if (r_state == S_UPD) begin
                r_oacc <= 1'b1;
                r_ocnt <= (r_op == OP_FILL) ? sat_cnt : mem_rdata;
            end else begin
                r_oacc <= 1'b0;
                r_ocnt <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_oacc;
    assign m_axis_tdata  = {(OUT_TDATA_W - BSP_W - BCH_W - CNT_W)'(0), r_ocnt, r_obch, r_obsp};

endmodule

// ----- rtl/ghf_checker.sv -----
`include "assert_macros.svh"

module ghf_checker
    import ghf_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]             m_axis_tuser
);

    // a stalled result stays offered
    `CHK_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")

    // a stalled result keeps its payload
    `CHK_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // input is not ready in the cycle after a beat is taken
    `CHK_ASSERT(a_busy_after_beat, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "beat taken on consecutive cycles")

    // a rejected item reports a zero count
    `CHK_ASSERT(a_reject_zero, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[48:17] == 32'd0, "rejected result with nonzero count")

    // a new result comes from a busy sequencer
    `CHK_ASSERT(a_result_source, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result appeared from an idle block")

endmodule

bind gated_histogram_filler ghf_checker u_ghf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
